// ===== rtl/assert_macros.svh =====
// Assertion helpers; clk and rst are taken from the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define WCI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wci check failed");

// Next-cycle implication.
`define WCI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wci check failed");

`endif

// ===== rtl/wci_pkg.sv =====
package wci_pkg;

  localparam int STORE_DEPTH = 16;
  localparam int AXES        = 4;
  localparam int NUM_AXES    = 4;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int AX_W        = $clog2(NUM_AXES);
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_CLEAR  = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [1:0] MODE_ZACC = 2'd0;
  localparam logic [1:0] MODE_HERM = 2'd1;
  localparam logic [1:0] MODE_LIN  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_ZDUR  = 2'd3;

  typedef logic [NUM_AXES-1:0][31:0] pos_arr_t;

  typedef struct packed {
    logic [31:0] t;
    logic [1:0]  md;
    pos_arr_t    p;
    pos_arr_t    v;
  } wpt_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] stamp;
    logic [1:0]  mode;
    pos_arr_t    p;
    pos_arr_t    v;
  } qent_t;

  // axes beyond AXES read as zero
  function automatic pos_arr_t mask_pos(input pos_arr_t p);
    pos_arr_t r;
    for (int i = 0; i < NUM_AXES; i++) begin
      r[i] = (i < AXES) ? p[i] : 32'd0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/waypoint_cubic_interpolator.sv =====
// Cubic waypoint trajectory interpolator, four axes, Q16.16.
// Input channel: an item transfers at a clock edge with start high and busy
// low. func selects append (stamp, mode, pos_*, vel_* form a waypoint), clear,
// or query (stamp only). Every item gives exactly one result.
// Output channel: result_strobe is high for one cycle with out_a..out_d,
// done_res and status; the receiver takes it then and cannot stall it.
// Items first enter a two-entry queue; busy is high only while it is full.
// Append, clear and empty-store query are answered from the execute state.
// A query scans the store one entry per cycle through the single read port,
// runs a restoring divider for the segment fraction, then shares one 48x12
// multiplier over the axes, with one product term per axis for linear, two
// for zero accel and three for Hermite; items are worked one at a time.
// Reset clears the waypoint count and the queue; stored waypoints are not
// cleared and are never read before being written.
module waypoint_cubic_interpolator import wci_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic [31:0]        stamp,
  input  logic [1:0]         mode,
  input  logic signed [31:0] pos_a,
  input  logic signed [31:0] pos_b,
  input  logic signed [31:0] pos_c,
  input  logic signed [31:0] pos_d,
  input  logic signed [31:0] vel_a,
  input  logic signed [31:0] vel_b,
  input  logic signed [31:0] vel_c,
  input  logic signed [31:0] vel_d,
  output logic               result_strobe,
  output logic signed [31:0] out_a,
  output logic signed [31:0] out_b,
  output logic signed [31:0] out_c,
  output logic signed [31:0] out_d,
  output logic               done_res,
  output logic [1:0]         status
);

  pos_arr_t pos_in;
  pos_arr_t vel_in;
  pos_arr_t res_pos;
  qent_t    f_ent;
  qent_t    q_data;
  logic     push;
  logic     full;
  logic     q_empty;
  logic     q_pop;

  assign pos_in = {pos_d, pos_c, pos_b, pos_a};
  assign vel_in = {vel_d, vel_c, vel_b, vel_a};

  wci_front u_front (
    .start (start),
    .func  (func),
    .stamp (stamp),
    .mode  (mode),
    .pos   (pos_in),
    .vel   (vel_in),
    .full  (full),
    .busy  (busy),
    .push  (push),
    .ent   (f_ent)
  );

  wci_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (f_ent),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_data),
    .empty (q_empty)
  );

  wci_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .strobe     (result_strobe),
    .res_pos    (res_pos),
    .res_done   (done_res),
    .res_status (status)
  );

  assign out_a = $signed(res_pos[0]);
  assign out_b = $signed(res_pos[1]);
  assign out_c = $signed(res_pos[2]);
  assign out_d = $signed(res_pos[3]);

endmodule

// ===== rtl/wci_ram.sv =====
module wci_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/wci_front.sv =====
module wci_front import wci_pkg::*; (
  input  logic        start,
  input  logic [1:0]  func,
  input  logic [31:0] stamp,
  input  logic [1:0]  mode,
  input  pos_arr_t    pos,
  input  pos_arr_t    vel,
  input  logic        full,
  output logic        busy,
  output logic        push,
  output qent_t       ent
);

  assign busy = full;
  assign push = start && !full;

  always_comb begin
    case (func)
      FUNC_APPEND: ent.op = OP_APPEND;
      FUNC_CLEAR:  ent.op = OP_CLEAR;
      FUNC_QUERY:  ent.op = OP_QUERY;
      default:     ent.op = OP_NOP;
    endcase
    // unused mode code falls back to linear
    case (mode)
      MODE_ZACC: ent.mode = MODE_ZACC;
      MODE_HERM: ent.mode = MODE_HERM;
      default:   ent.mode = MODE_LIN;
    endcase
    ent.stamp = stamp;
    ent.p     = pos;
    ent.v     = vel;
  end

endmodule

// ===== rtl/wci_queue.sv =====
module wci_queue import wci_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t din,
  output logic  full,
  input  logic  pop,
  output qent_t dout,
  output logic  empty
);

  qent_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        slots[wptr] <= din;
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/wci_back.sv =====
module wci_back import wci_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  qent_t       q_data,
  output logic        q_pop,
  output logic        strobe,
  output pos_arr_t    res_pos,
  output logic        res_done,
  output logic [1:0]  res_status
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_GLAST = 4'd2;
  localparam logic [3:0] S_G0    = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_ELAST = 4'd5;
  localparam logic [3:0] S_SEG   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_SQ    = 4'd8;
  localparam logic [3:0] S_CU    = 4'd9;
  localparam logic [3:0] S_AXIS  = 4'd10;
  localparam logic [3:0] S_VT0   = 4'd11;
  localparam logic [3:0] S_VT1   = 4'd12;
  localparam logic [3:0] S_TERM  = 4'd13;
  localparam logic [3:0] S_MUL   = 4'd14;
  localparam logic [3:0] S_ACC   = 4'd15;

  localparam logic signed [63:0] SMAX = 64'sd2147483647;
  localparam logic signed [63:0] SMIN = -64'sd2147483648;

  logic [3:0]        state;
  qent_t             cmd;
  logic [CNT_W-1:0]  cnt;
  logic [IDX_W-1:0]  idx;
  wpt_t              lst;
  wpt_t              pw;
  wpt_t              nw;
  logic              done_q;
  logic [31:0]       dur;
  logic [31:0]       rem;
  logic [31:0]       quo;
  logic [4:0]        dcnt;
  logic [31:0]       s2;
  logic [31:0]       s3;
  logic [AX_W-1:0]   ax;
  logic [1:0]        tk;
  logic signed [63:0] acc;
  logic signed [48:0] dlt;
  logic signed [48:0] v0t;
  logic signed [48:0] v1t;
  logic [47:0]       ma;
  logic [35:0]       mb;
  logic              neg;
  logic [1:0]        dig;
  logic [83:0]       prod;
  pos_arr_t          res;

  logic              ram_we;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [$bits(wpt_t)-1:0] ram_rdata;
  wpt_t              rd;
  wpt_t              wr;
  logic [CNT_W-1:0]  idx_inc;

  assign rd      = wpt_t'(ram_rdata);
  assign idx_inc = CNT_W'(idx) + 1'b1;
  assign wr.t    = cmd.stamp;
  assign wr.md   = cmd.mode;
  assign wr.p    = cmd.p;
  assign wr.v    = cmd.v;

  wci_ram #(.WIDTH($bits(wpt_t)), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt[IDX_W-1:0]),
    .wdata (wr),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      S_EXEC: begin
        if (cmd.op == OP_APPEND && cnt < CNT_W'(STORE_DEPTH)) begin
          ram_we = 1'b1;
        end else if (cmd.op == OP_QUERY && cnt != '0) begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(cnt - 1'b1);
        end
      end
      S_GLAST: begin
        ram_re = (cnt != CNT_W'(1));
      end
      S_G0: begin
        ram_re    = 1'b1;
        ram_raddr = IDX_W'(1);
      end
      S_CHK: begin
        if (rd.t <= cmd.stamp && idx_inc < cnt) begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc[IDX_W-1:0];
        end
      end
      default: ;
    endcase
  end

  assign q_pop = (state == S_IDLE) && !q_empty;

  // basis values, all well inside 36 bits signed
  logic signed [35:0] es, es2, es3, h01, h10, h11, hg, hsg, gsum;
  assign es   = $signed({4'b0, quo});
  assign es2  = $signed({4'b0, s2});
  assign es3  = $signed({4'b0, s3});
  assign h01  = es2 + es2 + es2 - es3 - es3;
  assign h10  = es - es2 - es2 + es3;
  assign h11  = es3 - es2;
  assign gsum = es2 + es2 + es2 - es3;
  assign hg   = gsum >>> 1;
  assign hsg  = es - hg;

  logic [32:0] rem2;
  assign rem2 = {rem, 1'b0};

  logic [63:0] sq_prod;
  assign sq_prod = (state == S_SQ) ? quo * quo : s2 * quo;

  // |v| * T / 2^16, sign restored
  logic signed [31:0] vsel;
  logic [31:0]        vmag;
  logic [63:0]        vprod;
  logic signed [48:0] vt;
  assign vsel  = (state == S_VT0) ? $signed(pw.v[ax]) : $signed(nw.v[ax]);
  assign vmag  = vsel[31] ? 32'(-vsel) : 32'(vsel);
  assign vprod = vmag * dur;
  assign vt    = vsel[31] ? -$signed({1'b0, vprod[63:16]}) : $signed({1'b0, vprod[63:16]});

  logic signed [48:0] op_a;
  logic signed [35:0] op_b;
  logic [1:0]         last_tk;
  always_comb begin
    op_a = dlt;
    op_b = es;
    case (nw.md)
      MODE_HERM: begin
        last_tk = 2'd2;
        case (tk)
          2'd0:    begin op_a = dlt; op_b = h01; end
          2'd1:    begin op_a = v0t; op_b = h10; end
          default: begin op_a = v1t; op_b = h11; end
        endcase
      end
      MODE_ZACC: begin
        last_tk = 2'd1;
        if (tk == 2'd0) begin
          op_b = hg;
        end else begin
          op_a = v0t;
          op_b = hsg;
        end
      end
      default: last_tk = 2'd0;
    endcase
  end

  logic [11:0] digit;
  logic [59:0] part;
  logic [83:0] part_sh;
  always_comb begin
    case (dig)
      2'd0:    digit = mb[11:0];
      2'd1:    digit = mb[23:12];
      default: digit = mb[35:24];
    endcase
    part = ma * digit;
    case (dig)
      2'd0:    part_sh = {24'b0, part};
      2'd1:    part_sh = {12'b0, part, 12'b0};
      default: part_sh = {part, 24'b0};
    endcase
  end

  logic signed [63:0] pr;
  logic signed [63:0] acc_next;
  assign pr       = $signed({12'b0, prod[83:32]});
  assign acc_next = neg ? acc - pr : acc + pr;

  logic [31:0] sat;
  assign sat = (acc_next > SMAX) ? SMAX[31:0] :
               (acc_next < SMIN) ? SMIN[31:0] : acc_next[31:0];

  // finished axes plus the one completing this cycle
  pos_arr_t res_fin;
  always_comb begin
    res_fin     = res;
    res_fin[ax] = sat;
  end

  logic [31:0] ust;
  assign ust = (cmd.stamp >= pw.t) ? cmd.stamp - pw.t : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      strobe <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          // strobe is only ever raised on the way into idle
          strobe <= 1'b0;
          if (!q_empty) begin
            cmd   <= q_data;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_pos  <= '0;
          res_done <= 1'b0;
          if (cmd.op == OP_QUERY && cnt != '0) begin
            state <= S_GLAST;
          end else begin
            strobe <= 1'b1;
            state  <= S_IDLE;
            case (cmd.op)
              OP_APPEND: begin
                if (cnt < CNT_W'(STORE_DEPTH)) begin
                  cnt        <= cnt + 1'b1;
                  res_status <= ST_OK;
                end else begin
                  res_status <= ST_FULL;
                end
              end
              OP_CLEAR: begin
                cnt        <= '0;
                res_status <= ST_OK;
              end
              OP_QUERY: res_status <= ST_EMPTY;
              default:  res_status <= ST_OK;
            endcase
          end
        end
        S_GLAST: begin
          lst    <= rd;
          done_q <= (cmd.stamp >= rd.t);
          state  <= (cnt == CNT_W'(1)) ? S_ELAST : S_G0;
        end
        S_G0: begin
          nw    <= rd;
          idx   <= IDX_W'(1);
          state <= S_CHK;
        end
        S_CHK: begin
          if (rd.t <= cmd.stamp) begin
            nw <= rd;
            if (idx_inc >= cnt) begin
              state <= S_ELAST;
            end else begin
              idx <= idx_inc[IDX_W-1:0];
            end
          end else begin
            pw    <= nw;
            nw    <= rd;
            state <= S_SEG;
          end
        end
        S_ELAST: begin
          res_pos    <= mask_pos(lst.p);
          res_done   <= done_q;
          res_status <= ST_OK;
          strobe     <= 1'b1;
          state      <= S_IDLE;
        end
        S_SEG: begin
          if (nw.t <= pw.t) begin
            res_pos    <= mask_pos(pw.p);
            res_done   <= done_q;
            res_status <= ST_ZDUR;
            strobe     <= 1'b1;
            state      <= S_IDLE;
          end else begin
            dur   <= nw.t - pw.t;
            rem   <= ust;
            dcnt  <= '0;
            res   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (rem2 >= {1'b0, dur}) begin
            rem <= 32'(rem2 - {1'b0, dur});
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= rem2[31:0];
            quo <= {quo[30:0], 1'b0};
          end
          dcnt <= dcnt + 1'b1;
          if (dcnt == 5'd31) begin
            state <= S_SQ;
          end
        end
        S_SQ: begin
          s2    <= sq_prod[63:32];
          state <= S_CU;
        end
        S_CU: begin
          s3    <= sq_prod[63:32];
          ax    <= '0;
          state <= S_AXIS;
        end
        S_AXIS: begin
          acc   <= 64'($signed(pw.p[ax]));
          dlt   <= 49'($signed(nw.p[ax])) - 49'($signed(pw.p[ax]));
          tk    <= '0;
          state <= S_VT0;
        end
        S_VT0: begin
          v0t   <= vt;
          state <= S_VT1;
        end
        S_VT1: begin
          v1t   <= vt;
          state <= S_TERM;
        end
        S_TERM: begin
          ma    <= op_a[48] ? 48'(-op_a) : 48'(op_a);
          mb    <= op_b[35] ? 36'(-op_b) : 36'(op_b);
          neg   <= op_a[48] ^ op_b[35];
          prod  <= '0;
          dig   <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= prod + part_sh;
          dig  <= dig + 1'b1;
          if (dig == 2'd2) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (tk == last_tk) begin
            res[ax] <= sat;
            if (ax == AX_W'(AXES - 1)) begin
              res_pos    <= res_fin;
              res_done   <= done_q;
              res_status <= ST_OK;
              strobe     <= 1'b1;
              state      <= S_IDLE;
            end else begin
              ax    <= ax + 1'b1;
              state <= S_AXIS;
            end
          end else begin
            acc   <= acc_next;
            tk    <= tk + 1'b1;
            state <= S_TERM;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/wci_check.sv =====
`include "assert_macros.svh"

module wci_check import wci_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               result_strobe,
  input logic signed [31:0] out_a,
  input logic               done_res,
  input logic [1:0]         status
);

  // items transferred in but not yet answered
  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if ((start && !busy) && !result_strobe) begin
      pending <= pending + 1'b1;
    end else if (!(start && !busy) && result_strobe) begin
      pending <= pending - 1'b1;
    end
  end

  `WCI_ASSERT_NEXT(a_strobe_gap, result_strobe, !result_strobe)
  `WCI_ASSERT_IMP(a_no_orphan, result_strobe, pending != 3'd0)
  `WCI_ASSERT_IMP(a_bounded, 1'b1, pending <= 3'd3)
  `WCI_ASSERT_IMP(a_empty_zero, result_strobe && status == ST_EMPTY, out_a == 0 && !done_res)

endmodule

bind waypoint_cubic_interpolator wci_check u_check (.*);

// ===== tb/waypoint_cubic_interpolator_test.sv =====
module waypoint_cubic_interpolator_test;
  import wci_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] func = FUNC_CLEAR;
  logic [31:0] stamp = '0;
  logic [1:0] mode = MODE_LIN;
  logic signed [31:0] pos_a = '0, pos_b = '0, pos_c = '0, pos_d = '0;
  logic signed [31:0] vel_a = '0, vel_b = '0, vel_c = '0, vel_d = '0;
  logic result_strobe;
  logic signed [31:0] out_a, out_b, out_c, out_d;
  logic done_res;
  logic [1:0] status;

  waypoint_cubic_interpolator DUT (.*);

  initial forever #5 clk = ~clk;

  typedef struct {
    logic signed [31:0] p [4];
    logic done;
    logic [1:0] st;
  } setpoint_t;

  typedef struct {
    logic [31:0] t;
    logic [1:0] md;
    longint p [4];
    longint v [4];
  } waypt_t;

  waypt_t path [STORE_DEPTH];
  int unsigned path_len = 0;
  setpoint_t pending_q [$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int idle_pct = 11;
  int watchdog = 0;
  localparam int WATCHDOG_LIMIT = 20000;

  function automatic logic signed [31:0] sat32(longint x);
    if (x > 64'sd2147483647) return 32'h7fffffff;
    if (x < -64'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  // (a*b)/2^32 toward zero; operands fit in 128 bits
  function automatic longint mulq32(longint a, longint b);
    logic signed [127:0] pr;
    logic [127:0] m;
    longint r;
    pr = 128'(signed'(a)) * 128'(signed'(b));
    m = pr[127] ? -pr : pr;
    r = longint'(m >> 32);
    return pr[127] ? -r : r;
  endfunction

  function automatic longint vel_dur(longint v, longint dur);
    longint m, r;
    m = v < 0 ? -v : v;
    r = (m * dur) >>> 16;
    return v < 0 ? -r : r;
  endfunction

  function automatic setpoint_t predict_setpoint(logic [1:0] f, logic [31:0] ts, logic [1:0] md,
      logic signed [31:0] pp [4], logic signed [31:0] vv [4]);
    setpoint_t e;
    int nx;
    longint dur, u, s, s2, s3, h01, h10, h11, g, x0, d, r;
    logic [127:0] tmp;
    e.p = '{0, 0, 0, 0};
    e.done = 0;
    e.st = ST_OK;
    case (f)
      FUNC_APPEND: begin
        if (path_len >= STORE_DEPTH) e.st = ST_FULL;
        else begin
          path[path_len].t = ts;
          path[path_len].md = md;
          for (int a = 0; a < 4; a++) begin
            path[path_len].p[a] = pp[a];
            path[path_len].v[a] = vv[a];
          end
          path_len++;
        end
      end
      FUNC_CLEAR: path_len = 0;
      FUNC_QUERY: begin
        if (path_len == 0) e.st = ST_EMPTY;
        else begin
          e.done = ts >= path[path_len-1].t;
          nx = 1;
          while (nx < path_len && path[nx].t <= ts) nx++;
          if (nx >= path_len) begin
            for (int a = 0; a < 4; a++) e.p[a] = (a < AXES) ? sat32(path[path_len-1].p[a]) : 0;
          end else if (path[nx].t <= path[nx-1].t) begin
            for (int a = 0; a < 4; a++) e.p[a] = (a < AXES) ? sat32(path[nx-1].p[a]) : 0;
            e.st = ST_ZDUR;
          end else begin
            dur = longint'(path[nx].t) - longint'(path[nx-1].t);
            u = (ts >= path[nx-1].t) ? longint'(ts) - longint'(path[nx-1].t) : 0;
            tmp = (128'(u) << 32) / 128'(dur);
            s = longint'(tmp);
            tmp = (128'(s) * 128'(s)) >> 32;
            s2 = longint'(tmp);
            tmp = (128'(s2) * 128'(s)) >> 32;
            s3 = longint'(tmp);
            h01 = 3 * s2 - 2 * s3;
            h10 = s - 2 * s2 + s3;
            h11 = s3 - s2;
            g = (3 * s2 - s3) >>> 1;
            for (int a = 0; a < AXES; a++) begin
              x0 = path[nx-1].p[a];
              d = path[nx].p[a] - x0;
              if (path[nx].md == MODE_HERM)
                r = x0 + mulq32(d, h01) + mulq32(vel_dur(path[nx-1].v[a], dur), h10)
                    + mulq32(vel_dur(path[nx].v[a], dur), h11);
              else if (path[nx].md == MODE_ZACC)
                r = x0 + mulq32(d, g) + mulq32(vel_dur(path[nx-1].v[a], dur), s - g);
              else r = x0 + mulq32(d, s);
              e.p[a] = sat32(r);
            end
          end
        end
      end
      default: ;
    endcase
    return e;
  endfunction

  // start stays high between back-to-back items; it drops only while idling
  task automatic send_item(logic [1:0] f, logic [31:0] ts, logic [1:0] md,
      logic signed [31:0] pp [4], logic signed [31:0] vv [4]);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    func <= f; stamp <= ts; mode <= md;
    pos_a <= pp[0]; pos_b <= pp[1]; pos_c <= pp[2]; pos_d <= pp[3];
    vel_a <= vv[0]; vel_b <= vv[1]; vel_c <= vv[2]; vel_d <= vv[3];
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(predict_setpoint(f, ts, md, pp, vv));
    sent++;
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(2000) - 1000;
      3: return ($urandom_range(20) - 10) << 16;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_waypoint(logic [31:0] ts, logic [1:0] md);
    logic signed [31:0] pp [4], vv [4];
    for (int a = 0; a < 4; a++) begin
      pp[a] = rnd_val();
      vv[a] = rnd_val();
    end
    send_item(FUNC_APPEND, ts, md, pp, vv);
  endtask

  task automatic send_cmd(logic [1:0] f, logic [31:0] ts);
    logic signed [31:0] pp [4], vv [4];
    for (int a = 0; a < 4; a++) begin
      pp[a] = $urandom;
      vv[a] = $urandom;
    end
    send_item(f, ts, 2'($urandom), pp, vv);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_cmd(FUNC_QUERY, 32'd0);
    send_cmd(OP_NOP, 32'hffffffff);
    send_waypoint(32'h0001_0000, MODE_LIN);
    send_cmd(FUNC_QUERY, 32'd0);
    send_cmd(FUNC_QUERY, 32'hffffffff);
    send_waypoint(32'h0003_0000, MODE_HERM);
    send_waypoint(32'h0003_0000, MODE_ZACC);
    send_waypoint(32'h0005_0000, MODE_ZACC);
    send_waypoint(32'hffff_ffff, 2'd3);
    send_cmd(FUNC_QUERY, 32'd0);
    send_cmd(FUNC_QUERY, 32'h0002_0000);
    send_cmd(FUNC_QUERY, 32'h0003_0000);
    send_cmd(FUNC_QUERY, 32'h0004_8000);
    send_cmd(FUNC_QUERY, 32'h8000_0000);
    send_cmd(FUNC_QUERY, 32'hffff_ffff);
    for (int i = 0; i < 12; i++) send_waypoint(32'hffff_ffff, 2'($urandom));
    send_cmd(FUNC_QUERY, 32'h7fff_0000);
    send_cmd(FUNC_CLEAR, 32'd0);
    send_cmd(FUNC_QUERY, 32'd5);
  endtask

  task automatic test_random(int n);
    int k;
    logic [31:0] t;
    k = 0;
    while (k < n) begin
      if ($urandom_range(9) < 8) begin
        send_cmd(FUNC_CLEAR, $urandom); k++;
        t = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h0004_0000);
        for (int i = $urandom_range(1, 17); i > 0 && k < n; i--) begin
          send_waypoint(t, 2'($urandom)); k++;
          t = $urandom_range(7) == 0 ? t - $urandom_range(3) : t + $urandom_range(1, 32'h0003_0000);
        end
        for (int i = $urandom_range(1, 6); i > 0 && k < n; i--) begin
          send_cmd(FUNC_QUERY, $urandom_range(5) == 0 ? $urandom : $urandom_range(t + 32'h1_0000));
          k++;
        end
      end else begin
        send_cmd(2'($urandom), $urandom); k++;
      end
    end
  endtask

  task automatic test_pause();
    drain();
    repeat (20) @(posedge clk);
  endtask

  always @(posedge clk) begin
    setpoint_t e;
    if (!rst) begin
      if (result_strobe) begin
        received++;
        if (pending_q.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %h %h %h %h %b %0d",
                   $time, out_a, out_b, out_c, out_d, done_res, status);
          errors++;
        end else begin
          e = pending_q.pop_front();
          if ({out_a, out_b, out_c, out_d} !== {e.p[0], e.p[1], e.p[2], e.p[3]}) begin
            $display("%0t positions: expected %h %h %h %h, actual %h %h %h %h", $time,
                     e.p[0], e.p[1], e.p[2], e.p[3], out_a, out_b, out_c, out_d);
            errors++;
          end
          if (done_res !== e.done) begin
            $display("%0t done_res: expected %b, actual %b", $time, e.done, done_res);
            errors++;
          end
          if (status !== e.st) begin
            $display("%0t status: expected %0d, actual %0d", $time, e.st, status);
            errors++;
          end
        end
      end
      // transfer on either side resets the watchdog
      if (result_strobe || (start && !busy)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_pause();
    test_random(600);
    idle_pct = 65;
    test_random(600);
    test_pause();
    idle_pct = 0;
    test_random(620);
    drain();
    repeat (200) @(posedge clk);
    $display("Sent %0d items (append, clear, query, unused code), checked %0d results",
             sent, received);
    if (errors == 0 && pending_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
